### sv/kscb_pkg.sv
// shared types and constants for the keypad-set clock with batch counter
`default_nettype none

package kscb_pkg;

	// field types
	typedef logic [1:0] action_t;
	typedef logic [3:0] key_t;
	typedef logic [3:0] hour_t;
	typedef logic [5:0] minsec_t;
	typedef logic [2:0] mode_t;
	typedef logic [6:0] count_t;

	// one request as held in the input register
	typedef struct packed {
		action_t action;
		key_t    key_code;
	} item_t;

	// action codes
	localparam action_t ACT_TICK  = 2'd0;
	localparam action_t ACT_KEY   = 2'd1;
	localparam action_t ACT_PULSE = 2'd2;

	// key codes
	localparam key_t KEY_NEXT_MODE = 4'd15;
	localparam key_t KEY_DIGIT_END = 4'd10;

	// set modes
	localparam mode_t MODE_RUN    = 3'd0;
	localparam mode_t MODE_HOUR   = 3'd1;
	localparam mode_t MODE_MINUTE = 3'd2;
	localparam mode_t MODE_SECOND = 3'd3;
	localparam mode_t MODE_LIMIT  = 3'd4;

	// clock limits
	localparam minsec_t MINSEC_LAST  = 6'd59;
	localparam hour_t   HOUR_LAST    = 4'd12;
	localparam hour_t   HOUR_FIRST   = 4'd1;
	localparam count_t  HOUR_ENTRY_BAD   = 7'd13;
	localparam count_t  MINSEC_ENTRY_BAD = 7'd60;
	localparam count_t  COUNT_RESTART    = 7'd1;

endpackage

`default_nettype wire

### sv/kscb_in_reg.sv
// input register stage holding one accepted request
`default_nettype none

module kscb_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire kscb_pkg::action_t action,
	input  wire kscb_pkg::key_t    key_code,
	input  wire logic            out_free,
	output logic                 item_valid,
	output kscb_pkg::item_t      item
);
	import kscb_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  load;

	// stage can take a request when empty or draining this cycle
	assign load     = !valid_s1 || out_free;
	assign in_stall = !load;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1.action   <= action;
			item_s1.key_code <= key_code;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

`default_nettype wire

### sv/kscb_core.sv
// clock, keypad entry and batch counter state with its update logic
`default_nettype none

module kscb_core #(
	parameter int TICKS_PER_SECOND = 10
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            upd,
	input  wire kscb_pkg::item_t item,
	output kscb_pkg::hour_t      hours,
	output kscb_pkg::minsec_t    minutes,
	output kscb_pkg::minsec_t    seconds,
	output kscb_pkg::mode_t      set_mode,
	output kscb_pkg::count_t     count_limit,
	output kscb_pkg::count_t     product_count,
	output logic                 digit_position
);
	import kscb_pkg::*;

	localparam int TW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
	localparam logic [TW-1:0] TICK_LAST = TW'(TICKS_PER_SECOND - 1);

	logic [TW-1:0] tenth_q,  tenth_n;
	minsec_t       sec_q,    sec_n;
	minsec_t       min_q,    min_n;
	hour_t         hour_q,   hour_n;
	mode_t         mode_q,   mode_n;
	logic          pos_q,    pos_n;
	count_t        entry_q,  entry_n;
	count_t        limit_q,  limit_n;
	count_t        count_q,  count_n, count_pre;
	count_t        digit, tens;

	// digit value and its tens weight
	assign digit = 7'(item.key_code);
	assign tens  = (digit << 3) + (digit << 1);

	// next state for one request
	always_comb begin
		tenth_n   = tenth_q;
		sec_n     = sec_q;
		min_n     = min_q;
		hour_n    = hour_q;
		mode_n    = mode_q;
		pos_n     = pos_q;
		entry_n   = entry_q;
		limit_n   = limit_q;
		count_pre = count_q;
		unique case (item.action)
			ACT_TICK: begin
				if (tenth_q == TICK_LAST) begin
					tenth_n = '0;
					if (sec_q >= MINSEC_LAST) begin
						sec_n = '0;
						if (min_q >= MINSEC_LAST) begin
							min_n  = '0;
							hour_n = (hour_q >= HOUR_LAST) ? HOUR_FIRST : hour_q + 4'd1;
						end else begin
							min_n = min_q + 6'd1;
						end
					end else begin
						sec_n = sec_q + 6'd1;
					end
				end else begin
					tenth_n = tenth_q + TW'(1);
				end
			end
			ACT_KEY: begin
				if (item.key_code == KEY_NEXT_MODE) begin
					mode_n = (mode_q >= MODE_LIMIT) ? MODE_RUN : mode_q + 3'd1;
					pos_n  = 1'b0;
				end else if (item.key_code < KEY_DIGIT_END) begin
					entry_n = pos_q ? entry_q + digit : tens;
					if (mode_q == MODE_LIMIT) begin
						limit_n = pos_q ? limit_q + digit : tens;
					end
					pos_n = !pos_q;
					// copy entry to the selected field, restart on an out-of-range value
					if (mode_q == MODE_HOUR) begin
						if (entry_n >= HOUR_ENTRY_BAD) begin
							hour_n = HOUR_FIRST;
							pos_n  = 1'b0;
						end else begin
							hour_n = entry_n[3:0];
						end
					end else if (mode_q == MODE_MINUTE) begin
						if (entry_n >= MINSEC_ENTRY_BAD) begin
							min_n = '0;
							pos_n = 1'b0;
						end else begin
							min_n = entry_n[5:0];
						end
					end else if (mode_q == MODE_SECOND) begin
						if (entry_n >= MINSEC_ENTRY_BAD) begin
							sec_n = '0;
							pos_n = 1'b0;
						end else begin
							sec_n = entry_n[5:0];
						end
					end
				end
			end
			ACT_PULSE: begin
				count_pre = count_q + 7'd1;
			end
			default: begin
			end
		endcase
		// count past the limit falls back to one
		count_n = (count_pre > limit_n) ? COUNT_RESTART : count_pre;
	end

	// state registers, which also form the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tenth_q <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			mode_q  <= MODE_RUN;
			pos_q   <= 1'b0;
			entry_q <= '0;
			limit_q <= '0;
			count_q <= '0;
		end else if (upd) begin
			tenth_q <= tenth_n;
			sec_q   <= sec_n;
			min_q   <= min_n;
			hour_q  <= hour_n;
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			entry_q <= entry_n;
			limit_q <= limit_n;
			count_q <= count_n;
		end
	end

	assign hours          = hour_q;
	assign minutes        = min_q;
	assign seconds        = sec_q;
	assign set_mode       = mode_q;
	assign count_limit    = limit_q;
	assign product_count  = count_q;
	assign digit_position = pos_q;

	// mode key always restarts digit entry
	a_mode_key_pos: assert property (@(posedge clk) disable iff (!arst_n)
		upd && item.action == ACT_KEY && item.key_code == KEY_NEXT_MODE |=> !pos_q)
		else $error("digit position not cleared by mode key");

	// count stays within the limit or sits at one
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= limit_q || count_q == COUNT_RESTART)
		else $error("product count above limit");

	// time fields stay in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		hour_q <= HOUR_LAST && min_q <= MINSEC_LAST && sec_q <= MINSEC_LAST)
		else $error("time field out of range");

	// state holds when no request is applied
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(sec_q) && $stable(count_q) && $stable(mode_q) && $stable(tenth_q))
		else $error("state changed without a request");

	// a pulse never touches the time
	a_pulse_time: assert property (@(posedge clk) disable iff (!arst_n)
		upd && item.action == ACT_PULSE |=> $stable(sec_q) && $stable(min_q) && $stable(hour_q))
		else $error("product pulse changed the time");

endmodule

`default_nettype wire

### sv/keypad_set_clock_with_batch_counter_top.sv
// top level of the keypad-set twelve-hour clock with batch counter
// Usage:
//   Input channel (in_valid / in_stall) carries one event per request: action
//   selects a tenth-second tick, a keypad press (key_code) or a product pulse.
//   Output channel (out_valid / out_stall) returns one result per request with
//   hours, minutes, seconds, set_mode, count_limit, product_count and
//   digit_position as they stand after that event.
//   Path: an accepted request waits in the input register, then passes
//   through the update logic into the state registers; a stall can hold it.
//   Throughput: one request per cycle unless out_stall holds a result; the
//   state registers double as the result register, so the next request
//   uses the updated state directly.
//   Stall: while a result waits under out_stall, the input register still
//   takes one request; in_stall rises once that register is full.
//   Reset: arst_n clears all time, mode, entry and count state to zero and
//   empties both stages.
`default_nettype none

module keypad_set_clock_with_batch_counter_top #(
	parameter int TICKS_PER_SECOND = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire kscb_pkg::action_t action,
	input  wire kscb_pkg::key_t    key_code,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output kscb_pkg::hour_t        hours,
	output kscb_pkg::minsec_t      minutes,
	output kscb_pkg::minsec_t      seconds,
	output kscb_pkg::mode_t        set_mode,
	output kscb_pkg::count_t       count_limit,
	output kscb_pkg::count_t       product_count,
	output logic                   digit_position
);
	import kscb_pkg::*;

	logic  out_free;
	logic  item_valid;
	item_t item;
	logic  upd;
	logic  out_valid_q;

	// result slot is free when empty or being taken
	assign out_free = !out_valid_q || !out_stall;
	assign upd      = item_valid && out_free;

	kscb_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.key_code   (key_code),
		.out_free   (out_free),
		.item_valid (item_valid),
		.item       (item)
	);

	kscb_core #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.upd            (upd),
		.item           (item),
		.hours          (hours),
		.minutes        (minutes),
		.seconds        (seconds),
		.set_mode       (set_mode),
		.count_limit    (count_limit),
		.product_count  (product_count),
		.digit_position (digit_position)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= item_valid;
		end
	end

	assign out_valid = out_valid_q;

	// a request in the input register moves on whenever the result slot frees up
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && out_free |=> out_valid_q)
		else $error("request lost between stages");

	// a held result stays valid under stall
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(hours) && $stable(product_count))
		else $error("stalled result changed");

	// input is only refused while both stages are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> item_valid && out_valid_q && out_stall)
		else $error("input stalled with room available");

endmodule

`default_nettype wire
